// ----- sv/assert_macros.svh -----
// Assertion helpers for the checker file bchk_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/bchk_pkg.sv -----
package bchk_pkg;

	// Width of the action mask field
	localparam int NUM_KEYS = 12;

	// Action bit positions used by the chords
	localparam int BIT_MENU   = 6;
	localparam int BIT_BACK   = 8;
	localparam int BIT_SLEFT  = 10;
	localparam int BIT_SRIGHT = 11;

	localparam logic [NUM_KEYS-1:0] CHORD_PAIR  = NUM_KEYS'((1 << BIT_MENU) | (1 << BIT_BACK));
	localparam logic [NUM_KEYS-1:0] CHORD_RESET =
		NUM_KEYS'((1 << BIT_SLEFT) | (1 << BIT_SRIGHT) | (1 << BIT_BACK));
	localparam logic [NUM_KEYS-1:0] PART_STRAFE = NUM_KEYS'((1 << BIT_SLEFT) | (1 << BIT_SRIGHT));
	localparam logic [NUM_KEYS-1:0] PART_LBACK  = NUM_KEYS'((1 << BIT_SLEFT) | (1 << BIT_BACK));
	localparam logic [NUM_KEYS-1:0] PART_RBACK  = NUM_KEYS'((1 << BIT_SRIGHT) | (1 << BIT_BACK));

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_PAIR_HOLD  = 1'b0,
		REG_RESET_HOLD = 1'b1
	} reg_idx_t;

	localparam logic [15:0] PAIR_HOLD_RST  = 16'd3000;
	localparam logic [15:0] RESET_HOLD_RST = 16'd5000;

	typedef enum logic [1:0] {
		KIND_RELEASE = 2'd0,
		KIND_PRESS   = 2'd1,
		KIND_PAIR    = 2'd2,
		KIND_FORGET  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [31:0]         now_ms;
		logic [NUM_KEYS-1:0] pressed_mask;
	} in_word_t;

	typedef struct packed {
		kind_t      event_kind;
		logic [3:0] binding_index;
		logic       last_of_run;
	} out_word_t;

	// Chord tracking state
	typedef struct packed {
		logic        pair_active;
		logic        pair_consumed;
		logic [31:0] pair_start_time;
		logic        reset_active;
		logic        reset_consumed;
		logic        reset_guard;
		logic [31:0] reset_start_time;
	} chord_state_t;

	// One poll's worth of results handed to the output serializer
	typedef struct packed {
		logic                req_valid;
		kind_t               req_kind;
		logic [NUM_KEYS-1:0] rel;
		logic [NUM_KEYS-1:0] prs;
	} ser_load_t;

	// Index of the lowest set bit (zero when none)
	function automatic logic [3:0] lowest_idx(input logic [NUM_KEYS-1:0] m);
		logic [3:0] idx;
		idx = '0;
		for (int i = NUM_KEYS - 1; i >= 0; i--) begin
			if (m[i]) begin
				idx = 4'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ----- sv/button_chord_hold_and_key_edges.sv -----
// Channel  | Handshake                 | Word
// ---------+---------------------------+---------------------------------------
// input    | in_valid / in_ready       | in_word  (now_ms, pressed_mask)
// output   | out_valid / out_ready     | out_word (event_kind, binding_index,
//          |                           |           last_of_run)
// config   | cfg_we                    | cfg_index, cfg_data
//
// A poll is held in the input register, then is decoded in one pass and its
// results are loaded into the output serializer, which sends one word per
// cycle while out_ready is high, one word for each result of the poll.
// The next poll is taken while the last word of the previous one is sent.
// Output stalls back up through the serializer into the input register.
// Reset clears all chord state and the published mask and restores hold times.
module button_chord_hold_and_key_edges import bchk_pkg::*; #(
	parameter int NUM_ACTIONS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_word_t    in_word,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_word,
	input  logic        cfg_we,
	input  reg_idx_t    cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int ACT_BITS = (NUM_ACTIONS < NUM_KEYS) ? NUM_ACTIONS : NUM_KEYS;
	localparam logic [NUM_KEYS-1:0] ACT_MASK = NUM_KEYS'((1 << ACT_BITS) - 1);

	logic [15:0]         pair_hold_q;
	logic [15:0]         reset_hold_q;
	in_word_t            in_s1;
	logic                in_valid_s1;
	chord_state_t        st_q;
	chord_state_t        st_nxt;
	logic [NUM_KEYS-1:0] pub_q;
	logic [NUM_KEYS-1:0] acts;
	logic [NUM_KEYS-1:0] filt;
	logic                req_valid;
	kind_t               req_kind;
	ser_load_t           ld;
	logic                ser_free;
	logic                load;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_hold_q  <= PAIR_HOLD_RST;
			reset_hold_q <= RESET_HOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAIR_HOLD:  pair_hold_q <= cfg_data;
				REG_RESET_HOLD: reset_hold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign load     = in_valid_s1 && ser_free;
	assign in_ready = !in_valid_s1 || load;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			in_valid_s1 <= 1'b1;
		end else if (load) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_word;
		end
	end

	assign acts = in_s1.pressed_mask & ACT_MASK;

	bchk_chord u_chord (
		.pairing_hold_ms (pair_hold_q),
		.reset_hold_ms   (reset_hold_q),
		.now_ms          (in_s1.now_ms),
		.acts            (acts),
		.st              (st_q),
		.st_nxt          (st_nxt),
		.filt            (filt),
		.req_valid       (req_valid),
		.req_kind        (req_kind)
	);

	// Chord state and published mask advance when the poll is handed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			pub_q <= '0;
		end else if (load) begin
			st_q  <= st_nxt;
			pub_q <= filt;
		end
	end

	assign ld.req_valid = req_valid;
	assign ld.req_kind  = req_kind;
	assign ld.rel       = pub_q & ~filt;
	assign ld.prs       = filt & ~pub_q;

	bchk_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.load_data (ld),
		.free      (ser_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

// ----- sv/bchk_chord.sv -----
module bchk_chord import bchk_pkg::*; (
	input  logic [15:0]         pairing_hold_ms,
	input  logic [15:0]         reset_hold_ms,
	input  logic [31:0]         now_ms,
	input  logic [NUM_KEYS-1:0] acts,
	input  chord_state_t        st,
	output chord_state_t        st_nxt,
	output logic [NUM_KEYS-1:0] filt,
	output logic                req_valid,
	output kind_t               req_kind
);

	logic        full_reset;
	logic        full_pair;
	logic        partial;
	logic [31:0] pair_start;
	logic [31:0] reset_start;
	logic        pair_held;
	logic        reset_held;

	assign full_reset = (acts & CHORD_RESET) == CHORD_RESET;
	assign full_pair  = (acts & CHORD_PAIR) == CHORD_PAIR;
	assign partial    = ((acts & PART_STRAFE) == PART_STRAFE) ||
	                    ((acts & PART_LBACK) == PART_LBACK) ||
	                    ((acts & PART_RBACK) == PART_RBACK);

	// Start time as it stands after this poll; elapsed time wraps mod 2^32
	assign pair_start  = st.pair_active ? st.pair_start_time : now_ms;
	assign reset_start = st.reset_active ? st.reset_start_time : now_ms;
	assign pair_held   = (now_ms - pair_start) >= {16'd0, pairing_hold_ms};
	assign reset_held  = (now_ms - reset_start) >= {16'd0, reset_hold_ms};

	// Chord decision for one poll
	always_comb begin
		st_nxt    = st;
		filt      = acts;
		req_valid = 1'b0;
		req_kind  = KIND_PAIR;
		if (full_reset) begin
			st_nxt.reset_guard      = 1'b1;
			st_nxt.reset_active     = 1'b1;
			st_nxt.reset_start_time = reset_start;
			if (!st.reset_consumed && reset_held) begin
				st_nxt.reset_consumed = 1'b1;
				req_valid             = 1'b1;
				req_kind              = KIND_FORGET;
			end
			filt = acts & ~CHORD_RESET;
		end else if (st.reset_guard) begin
			// hold the mask until every reset button is up
			if ((acts & CHORD_RESET) == '0) begin
				st_nxt.reset_guard    = 1'b0;
				st_nxt.reset_active   = 1'b0;
				st_nxt.reset_consumed = 1'b0;
			end
			filt = acts & ~CHORD_RESET;
		end else begin
			st_nxt.reset_active   = 1'b0;
			st_nxt.reset_consumed = 1'b0;
			if (full_pair) begin
				st_nxt.pair_active     = 1'b1;
				st_nxt.pair_start_time = pair_start;
				if (!st.pair_consumed && pair_held) begin
					st_nxt.pair_consumed = 1'b1;
					req_valid            = 1'b1;
					req_kind             = KIND_PAIR;
				end
				filt = acts & ~CHORD_PAIR;
			end else if (partial) begin
				st_nxt.reset_guard = 1'b1;
				filt               = acts & ~CHORD_RESET;
			end else if (st.pair_consumed) begin
				if ((acts & CHORD_PAIR) == '0) begin
					st_nxt.pair_active   = 1'b0;
					st_nxt.pair_consumed = 1'b0;
				end
				filt = acts & ~CHORD_PAIR;
			end else begin
				st_nxt.pair_active = 1'b0;
			end
		end
	end

endmodule

// ----- sv/bchk_ser.sv -----
module bchk_ser import bchk_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  ser_load_t load_data,
	output logic      free,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);

	logic                req_q;
	kind_t               kind_q;
	logic [NUM_KEYS-1:0] rel_q;
	logic [NUM_KEYS-1:0] prs_q;

	logic                rem_req;
	logic [NUM_KEYS-1:0] rem_rel;
	logic [NUM_KEYS-1:0] rem_prs;
	logic                fire;
	logic                last;

	// Pick the head word: request, then releases, then presses, low bit first
	always_comb begin
		rem_req = req_q;
		rem_rel = rel_q;
		rem_prs = prs_q;
		out_word.event_kind    = kind_q;
		out_word.binding_index = '0;
		if (req_q) begin
			rem_req = 1'b0;
		end else if (rel_q != '0) begin
			out_word.event_kind    = KIND_RELEASE;
			out_word.binding_index = lowest_idx(rel_q);
			rem_rel                = rel_q & (rel_q - NUM_KEYS'(1));
		end else begin
			out_word.event_kind    = KIND_PRESS;
			out_word.binding_index = lowest_idx(prs_q);
			rem_prs                = prs_q & (prs_q - NUM_KEYS'(1));
		end
		last                 = !rem_req && (rem_rel == '0) && (rem_prs == '0);
		out_word.last_of_run = last;
	end

	assign out_valid = req_q || (rel_q != '0) || (prs_q != '0);
	assign fire      = out_valid && out_ready;
	assign free      = !out_valid || (fire && last);

	// Pending words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= 1'b0;
			rel_q <= '0;
			prs_q <= '0;
		end else if (load) begin
			req_q <= load_data.req_valid;
			rel_q <= load_data.rel;
			prs_q <= load_data.prs;
		end else if (fire) begin
			req_q <= rem_req;
			rel_q <= rem_rel;
			prs_q <= rem_prs;
		end
	end

	// Request kind is payload only
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= load_data.req_kind;
		end
	end

endmodule

// ----- sv/bchk_checker.sv -----
`include "assert_macros.svh"

module bchk_checker import bchk_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_word
);

	logic fire;
	logic is_req;
	logic stall;
	logic mid_run;
	logic req_out;
	logic key_out;
	logic req_idx_ok;
	logic key_idx_ok;

	assign fire       = out_valid && out_ready;
	assign is_req     = (out_word.event_kind == KIND_PAIR) || (out_word.event_kind == KIND_FORGET);
	assign stall      = out_valid && !out_ready;
	assign mid_run    = fire && !out_word.last_of_run;
	assign req_out    = out_valid && is_req;
	assign key_out    = out_valid && !is_req;
	assign req_idx_ok = out_word.binding_index == 4'd0;
	assign key_idx_ok = out_word.binding_index < 4'(NUM_KEYS);

	// stalled word holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, stall, out_valid && $stable(out_word), "stall changed word")

	// requests carry no binding
	`ASSERT_IMPL(a_req_index, clk, arst_n, req_out, req_idx_ok, "request with nonzero binding index")

	// key events name a real action
	`ASSERT_IMPL(a_key_index, clk, arst_n, key_out, key_idx_ok, "binding index out of range")

	// a run continues until its last word
	`ASSERT_NEXT(a_run_cont, clk, arst_n, mid_run, out_valid, "run ended without last word")

	// at most one request per run, and it leads
	`ASSERT_NEXT(a_one_req, clk, arst_n, mid_run, !is_req, "request inside a run")

endmodule

bind button_chord_hold_and_key_edges bchk_checker u_bchk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);

// ----- tb/chord_event_checker.sv -----
module chord_event_checker import bchk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_word_t    in_word,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_word_t   out_word,
	input  logic        cfg_we,
	input  reg_idx_t    cfg_index,
	input  logic [15:0] cfg_data,
	output int          failures,
	output int          outstanding
);

	localparam int REPORT_LIMIT = 10;

	// Shadow of the hold registers and chord tracking
	logic [15:0]         pair_hold;
	logic [15:0]         reset_hold;
	logic [NUM_KEYS-1:0] shown_mask;
	chord_state_t        chord;

	// Event words still owed by the block, oldest first
	out_word_t expected_events[$];

	// Words of the poll being predicted
	out_word_t poll_events [0:NUM_KEYS];
	int        poll_count;
	int        error_total;

	function automatic void add_event(kind_t kind, logic [3:0] idx);
		poll_events[poll_count] = '{kind, idx, 1'b0};
		poll_count++;
	endfunction

	// Chord handling, filtering and edge detection for one poll
	function automatic void predict_poll(in_word_t w);
		logic [NUM_KEYS-1:0] acts;
		logic [NUM_KEYS-1:0] filt;
		logic [NUM_KEYS-1:0] changed;
		logic [31:0]         elapsed;
		acts = w.pressed_mask;
		poll_count = 0;
		if ((acts & CHORD_RESET) == CHORD_RESET) begin
			chord.reset_guard = 1'b1;
			if (!chord.reset_active) begin
				chord.reset_active = 1'b1;
				chord.reset_start_time = w.now_ms;
			end
			// elapsed time wraps modulo 2^32
			elapsed = w.now_ms - chord.reset_start_time;
			if (!chord.reset_consumed && elapsed >= 32'(reset_hold)) begin
				chord.reset_consumed = 1'b1;
				add_event(KIND_FORGET, 4'd0);
			end
			filt = acts & ~CHORD_RESET;
		end else if (chord.reset_guard) begin
			// guard holds until every reset button is up
			if ((acts & CHORD_RESET) == '0) begin
				chord.reset_guard = 1'b0;
				chord.reset_active = 1'b0;
				chord.reset_consumed = 1'b0;
			end
			filt = acts & ~CHORD_RESET;
		end else begin
			chord.reset_active = 1'b0;
			chord.reset_consumed = 1'b0;
			if ((acts & CHORD_PAIR) == CHORD_PAIR) begin
				if (!chord.pair_active) begin
					chord.pair_active = 1'b1;
					chord.pair_start_time = w.now_ms;
				end
				elapsed = w.now_ms - chord.pair_start_time;
				if (!chord.pair_consumed && elapsed >= 32'(pair_hold)) begin
					chord.pair_consumed = 1'b1;
					add_event(KIND_PAIR, 4'd0);
				end
				filt = acts & ~CHORD_PAIR;
			end else if ((acts & PART_STRAFE) == PART_STRAFE ||
					(acts & PART_LBACK) == PART_LBACK ||
					(acts & PART_RBACK) == PART_RBACK) begin
				// two of the three reset buttons arm the guard
				chord.reset_guard = 1'b1;
				filt = acts & ~CHORD_RESET;
			end else if (chord.pair_consumed) begin
				if ((acts & CHORD_PAIR) == '0) begin
					chord.pair_active = 1'b0;
					chord.pair_consumed = 1'b0;
				end
				filt = acts & ~CHORD_PAIR;
			end else begin
				chord.pair_active = 1'b0;
				filt = acts;
			end
		end

		// releases first, then presses, low bit first
		changed = filt ^ shown_mask;
		for (int i = 0; i < NUM_KEYS; i++)
			if (changed[i] && shown_mask[i]) add_event(KIND_RELEASE, 4'(i));
		for (int i = 0; i < NUM_KEYS; i++)
			if (changed[i] && filt[i]) add_event(KIND_PRESS, 4'(i));
		shown_mask = filt;

		if (poll_count > 0) poll_events[poll_count - 1].last_of_run = 1'b1;
		for (int i = 0; i < poll_count; i++) expected_events.push_back(poll_events[i]);
	endfunction

	// Compare one sent word with the oldest owed word
	function automatic void check_word(out_word_t got);
		out_word_t want;
		if (expected_events.size() == 0) begin
			error_total++;
			if (error_total <= REPORT_LIMIT)
				$display("unexpected word: kind=%0d idx=%0d last=%0d",
					got.event_kind, got.binding_index, got.last_of_run);
		end else begin
			want = expected_events.pop_front();
			if (got.event_kind !== want.event_kind ||
					got.binding_index !== want.binding_index ||
					got.last_of_run !== want.last_of_run) begin
				error_total++;
				if (error_total <= REPORT_LIMIT)
					$display("word mismatch: expected kind=%0d idx=%0d last=%0d,",
						want.event_kind, want.binding_index, want.last_of_run,
						" got kind=%0d idx=%0d last=%0d",
						got.event_kind, got.binding_index, got.last_of_run);
			end
		end
	endfunction

	// Sample all ports at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_hold = PAIR_HOLD_RST;
			reset_hold = RESET_HOLD_RST;
			shown_mask = '0;
			chord = '0;
			expected_events.delete();
			error_total = 0;
			failures <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PAIR_HOLD:  pair_hold = cfg_data;
					REG_RESET_HOLD: reset_hold = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) check_word(out_word);
			if (in_valid && in_ready) predict_poll(in_word);
			failures <= error_total;
			outstanding <= expected_events.size();
		end
	end

endmodule

// ----- tb/button_chord_hold_and_key_edges_test.sv -----
module button_chord_hold_and_key_edges_test;
	import bchk_pkg::*;

	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 12;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_word_t    in_word = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_word_t   out_word;
	logic        cfg_we = 1'b0;
	reg_idx_t    cfg_index = REG_PAIR_HOLD;
	logic [15:0] cfg_data = '0;
	int          failures;
	int          outstanding;

	logic        calm = 1'b0;
	int          stall_left = 0;
	int          idle_cycles = 0;
	int          polls_sent = 0;
	logic [31:0] clock_ms = '0;
	int          step_max = 0;

	button_chord_hold_and_key_edges #(.NUM_ACTIONS(NUM_KEYS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	chord_event_checker u_event_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_word     (in_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_word    (out_word),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always #4 clk = ~clk;

	// Receiver stalls in random bursts
	always @(posedge clk) begin
		if (calm) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (out_ready && $urandom_range(0, 9) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 17);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Watchdog: too long without any word moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Offer one poll word, with an optional gap first, and wait for acceptance
	task automatic send_poll(input logic [31:0] t, input logic [NUM_KEYS-1:0] mask);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= '{now_ms: t, pressed_mask: mask};
		do @(posedge clk); while (!in_ready);
		polls_sent++;
	endtask

	// Advance the poll clock, now and then jumping anywhere
	task automatic next_poll(input logic [NUM_KEYS-1:0] mask);
		if ($urandom_range(0, 39) == 0) clock_ms = $urandom;
		else clock_ms = clock_ms + 32'($urandom_range(0, step_max));
		send_poll(clock_ms, mask);
	endtask

	// Drain all owed words, then give the pipeline time to empty
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_holds(input logic [15:0] pair_ms, input logic [15:0] reset_ms);
		cfg_we <= 1'b1;
		cfg_index <= REG_PAIR_HOLD;
		cfg_data <= pair_ms;
		@(posedge clk);
		cfg_index <= REG_RESET_HOLD;
		cfg_data <= reset_ms;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// A chord held for a few polls with random other buttons, then let go
	task automatic episode();
		logic [NUM_KEYS-1:0] chord;
		logic [NUM_KEYS-1:0] free;
		logic [NUM_KEYS-1:0] mask;
		int pick;
		int len;
		free = ~(CHORD_PAIR | CHORD_RESET);
		pick = $urandom_range(0, 9);
		len = $urandom_range(1, 6);
		case (pick)
			0, 1, 2: chord = CHORD_PAIR;
			3, 4, 5: chord = CHORD_RESET;
			6:       chord = PART_STRAFE;
			7:       chord = ($urandom_range(0, 1) == 1) ? PART_LBACK : PART_RBACK;
			8:       chord = CHORD_PAIR | (NUM_KEYS'(1) << BIT_SRIGHT);
			default: chord = '0;
		endcase
		for (int k = 0; k < len; k++) begin
			if (chord == '0) begin
				mask = NUM_KEYS'($urandom);
			end else begin
				mask = chord | (NUM_KEYS'($urandom) & free);
				// now and then one button flips mid-hold
				if ($urandom_range(0, 7) == 0)
					mask = mask ^ (NUM_KEYS'(1) << $urandom_range(0, NUM_KEYS - 1));
			end
			next_poll(mask);
		end
		// part of the chord goes up first, then the rest
		next_poll((chord & NUM_KEYS'($urandom)) | (NUM_KEYS'($urandom) & free));
		next_poll(NUM_KEYS'($urandom) & free);
	endtask

	task automatic random_phase(input int upto, input int step);
		step_max = step;
		clock_ms = $urandom;
		while (polls_sent < upto) episode();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed polls with the hold times from reset
		send_poll(32'd0, 12'h000);
		send_poll(32'd100, 12'hFFF);
		send_poll(32'd200, 12'h000);
		// pairing chord: one ms short of the hold, then exactly at it
		send_poll(32'd1000, CHORD_PAIR);
		send_poll(32'd3999, CHORD_PAIR | 12'h001);
		send_poll(32'd4000, CHORD_PAIR | 12'h001);
		send_poll(32'd9000, CHORD_PAIR);
		send_poll(32'd9100, NUM_KEYS'(1) << BIT_MENU);
		send_poll(32'd9200, 12'h000);
		// reset chord to its hold, then a leftover button under the guard
		send_poll(32'd20000, CHORD_RESET | 12'h010);
		send_poll(32'd24999, CHORD_RESET);
		send_poll(32'd25000, CHORD_RESET);
		send_poll(32'd25100, NUM_KEYS'(1) << BIT_SLEFT);
		send_poll(32'd25200, 12'h000);
		// partial reset chords arm the guard
		send_poll(32'd30000, PART_STRAFE | 12'h002);
		send_poll(32'd30100, 12'h001);
		send_poll(32'd30200, PART_LBACK);
		send_poll(32'd30300, PART_RBACK | 12'h200);
		send_poll(32'd30400, 12'h000);
		// pairing hold across the time wrap
		send_poll(32'hFFFF_F000, CHORD_PAIR);
		send_poll(32'h0000_0200, CHORD_PAIR);
		send_poll(32'hFFFF_FFFF, CHORD_PAIR | (NUM_KEYS'(1) << BIT_SLEFT));
		send_poll(32'h0000_0200, 12'h000);
		send_poll(32'h0000_0300, 12'h555);
		send_poll(32'h0000_0400, 12'hAAA);

		// Zero holds fire on the first poll of a chord
		settle();
		set_holds(16'h0000, 16'h0000);
		random_phase(65, 20);

		settle();
		set_holds(16'($urandom_range(1, 150)), 16'($urandom_range(1, 150)));
		random_phase(105, 60);

		// Longest holds, with big time steps
		settle();
		set_holds(16'hFFFF, 16'hFFFF);
		random_phase(140, 40000);

		// Last stretch runs with no idling on either side
		settle();
		calm <= 1'b1;
		set_holds(16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)));
		random_phase(178, 200);

		settle();
		if (failures == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule
